// File: rtl/lscl_pkg.sv
package lscl_pkg;

   localparam int unsigned CODE_W   = 8;
   localparam int unsigned COUNT_W  = 12;
   localparam int unsigned LUX_W    = 21;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned EXP_W    = 17;
   localparam int unsigned FRAC_W   = 16;
   localparam int unsigned EXP_SPAN = 16;
   localparam int unsigned Q_BITS   = 30;
   localparam int unsigned TERMS    = 20;

   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_CH0_INVALID  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CH0_OVERFLOW = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CH1_INVALID  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CH1_OVERFLOW = 3'd4;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count_ch0;
      logic [COUNT_W-1:0]  count_ch1;
      logic [COUNT_W-1:0]  diff;
      logic                neg;
      logic                ext;
      logic                live;
   } meta_type;

   function automatic logic [COUNT_W-1:0] expand_code(logic [CODE_W-1:0] code);
      logic [2:0]  chord;
      logic [11:0] pow2;
      logic [17:0] base;
      chord = code[6:4];
      pow2  = 12'd1 << chord;
      base  = (18'd33 * 18'(pow2 - 12'd1)) >> 1;
      return COUNT_W'(base) + COUNT_W'({8'd0, code[3:0]} << chord);
   endfunction

   function automatic logic [63:0] div_small(logic [63:0] x, int unsigned n);
      logic [63:0] r;
      case (n)
         1:  r = x;
         2:  r = x / 2;
         3:  r = x / 3;
         4:  r = x / 4;
         5:  r = x / 5;
         6:  r = x / 6;
         7:  r = x / 7;
         8:  r = x / 8;
         9:  r = x / 9;
         10: r = x / 10;
         11: r = x / 11;
         12: r = x / 12;
         13: r = x / 13;
         14: r = x / 14;
         15: r = x / 15;
         16: r = x / 16;
         17: r = x / 17;
         18: r = x / 18;
         19: r = x / 19;
         20: r = x / 20;
         default: r = x;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] exp_neg_frac(logic [63:0] f);
      logic signed [63:0] sum;
      logic [63:0]        term;
      sum  = 64'sd1 <<< Q_BITS;
      term = 64'd1 << Q_BITS;
      for (int unsigned n = 1; n <= TERMS; n++) begin
         term = div_small((term * f) >> Q_BITS, n);
         if (n % 2 == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      return 64'(sum);
   endfunction

   function automatic logic [EXP_W-1:0] exp_entry(logic [63:0] xq);
      logic [63:0] whole;
      logic [63:0] v;
      logic [63:0] e1;
      whole = xq >> Q_BITS;
      v     = exp_neg_frac(xq & ((64'd1 << Q_BITS) - 64'd1));
      e1    = exp_neg_frac(64'd1 << Q_BITS);
      for (int unsigned i = 0; i < EXP_SPAN; i++) begin
         if (64'(i) < whole) begin
            v = (v * e1) >> Q_BITS;
         end
      end
      return EXP_W'((v + 64'd8192) >> 14);
   endfunction

endpackage

// File: rtl/light_sensor_code_to_lux_core.sv
// channel  dir  width  fields (low bit first)
// req      in   24     code_ch0[7:0] code_ch1[15:8] extended_range[16] zero[23:17]
// rsp      out  48     status[2:0] count_ch0[14:3] count_ch1[26:15] lux_hundredths[47:27]
//
// One item per cycle while req_tready is high;
// the divider resolves one quotient bit per stage.
// Reset (synchronous, high) empties the pipe and the result queue.
// The pipe never stalls; a result queue behind it absorbs rsp stalls, and
// req_tready drops only when every queue slot is spoken for.
module light_sensor_code_to_lux_core #(
   parameter int unsigned EXP_TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // code_ch0, code_ch1, extended_range, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // status, count_ch0, count_ch1, lux_hundredths
);

   localparam int unsigned AW   = $clog2(EXP_TABLE_DEPTH);
   localparam int unsigned QW   = AW + 16;
   localparam int unsigned DW   = 50 + AW;
   localparam int unsigned RI_W = $clog2(EXP_TABLE_DEPTH + 1);
   localparam int unsigned L    = 13 + QW;
   localparam int unsigned CAP  = L + 2;
   localparam int unsigned CW   = $clog2(CAP + 1);
   localparam int unsigned PW   = $clog2(CAP);
   localparam int unsigned SD   = 4;
   localparam int unsigned ST   = SD + QW;
   localparam int unsigned R10  = (1 << 24) / 10;
   localparam int unsigned R100 = (1 << 24) / 100;

   logic [lscl_pkg::EXP_W-1:0] rom [EXP_TABLE_DEPTH + 1];

   for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++) begin : g_rom
      localparam logic [63:0] XQ = ((64'(k) * 64'(lscl_pkg::EXP_SPAN)) << lscl_pkg::Q_BITS)
                                   / 64'(EXP_TABLE_DEPTH);
      localparam logic [lscl_pkg::EXP_W-1:0] V =
         (k < EXP_TABLE_DEPTH) ? lscl_pkg::exp_entry(XQ) : '0;
      assign rom[k] = V;
   end

   logic                 acc;
   logic [L-1:0]         v_ff;
   logic [L-1:0]         v_in;
   lscl_pkg::meta_type   meta_ff [L];
   lscl_pkg::meta_type   meta_in;

   assign acc  = req_tvalid & req_tready;
   assign v_in = {v_ff[L-2:0], acc};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // decode
   always_comb begin
      logic [7:0]  a;
      logic [7:0]  b;
      logic [11:0] c0;
      logic [11:0] c1;
      a  = req_tdata[7:0];
      b  = req_tdata[15:8];
      c0 = '0;
      c1 = '0;
      meta_in.status = lscl_pkg::ST_OK;
      if (!a[7]) begin
         meta_in.status = lscl_pkg::ST_CH0_INVALID;
      end else begin
         c0 = lscl_pkg::expand_code(a);
         if (a[6:0] == 7'h7f) begin
            meta_in.status = lscl_pkg::ST_CH0_OVERFLOW;
         end else if (!b[7]) begin
            meta_in.status = lscl_pkg::ST_CH1_INVALID;
         end else begin
            c1 = lscl_pkg::expand_code(b);
            if (b[6:0] == 7'h7f) begin
               meta_in.status = lscl_pkg::ST_CH1_OVERFLOW;
            end
         end
      end
      meta_in.count_ch0 = c0;
      meta_in.count_ch1 = c1;
      meta_in.neg       = c1 > c0;
      meta_in.diff      = (c1 > c0) ? c1 - c0 : c0 - c1;
      meta_in.ext       = req_tdata[16];
      meta_in.live      = (meta_in.status == lscl_pkg::ST_OK) && (c0 != c1);
   end

   always_ff @(posedge clock) begin
      meta_ff[0] <= meta_in;
      for (int i = 1; i < L; i++) begin
         meta_ff[i] <= meta_ff[i-1];
      end
   end

   // squares, scaled numerator and denominator
   logic [23:0]   c1sq_ff;
   logic [23:0]   dsq_ff;
   logic [DW-1:0] num_ff;
   logic [33:0]   den3_ff;

   always_ff @(posedge clock) begin
      c1sq_ff <= 24'(meta_ff[0].count_ch1) * 24'(meta_ff[0].count_ch1);
      dsq_ff  <= 24'(meta_ff[0].diff) * 24'(meta_ff[0].diff);
      num_ff  <= (DW'(c1sq_ff) * DW'(181 * EXP_TABLE_DEPTH)) << 12;
      den3_ff <= 34'(dsq_ff) * 34'd1000;
   end

   // divider: one quotient bit per stage
   logic [DW-1:0] rem_ff [QW+1];
   logic [QW-1:0] quo_ff [QW+1];
   logic [33:0]   den_ff [QW+1];
   logic          sat_ff [QW+1];

   always_ff @(posedge clock) begin
      rem_ff[0] <= num_ff;
      quo_ff[0] <= '0;
      den_ff[0] <= den3_ff;
      sat_ff[0] <= num_ff >= (DW'(den3_ff) << QW);
   end

   for (genvar j = 0; j < QW; j++) begin : g_div
      logic [DW-1:0] sh;
      assign sh = DW'(den_ff[j]) << (QW - 1 - j);
      always_ff @(posedge clock) begin
         den_ff[j+1] <= den_ff[j];
         sat_ff[j+1] <= sat_ff[j];
         if (rem_ff[j] >= sh) begin
            rem_ff[j+1] <= rem_ff[j] - sh;
            quo_ff[j+1] <= quo_ff[j] | (QW'(1) << (QW - 1 - j));
         end else begin
            rem_ff[j+1] <= rem_ff[j];
            quo_ff[j+1] <= quo_ff[j];
         end
      end
   end

   // table read, interpolation, scaling
   logic [AW-1:0]               idx;
   logic                        far;
   logic [RI_W-1:0]             ix;
   logic [lscl_pkg::EXP_W-1:0]  tlo_ff;
   logic [lscl_pkg::EXP_W-1:0]  thi_ff;
   logic [15:0]                 fr_ff;
   logic                        far1_ff;
   logic                        far2_ff;
   logic [33:0]                 p0_ff;
   logic [33:0]                 p1_ff;
   logic [lscl_pkg::EXP_W-1:0]  e_ff;
   logic [28:0]                 de_ff;
   logic [36:0]                 n_ff;

   assign idx = quo_ff[QW][QW-1:16];
   assign far = sat_ff[QW] || (idx >= AW'(EXP_TABLE_DEPTH - 1));
   assign ix  = far ? '0 : RI_W'(idx);

   always_ff @(posedge clock) begin
      tlo_ff  <= rom[ix];
      thi_ff  <= rom[ix + RI_W'(1)];
      fr_ff   <= quo_ff[QW][15:0];
      far1_ff <= far;
      p0_ff   <= 34'(tlo_ff) * 34'(17'h10000 - 17'(fr_ff));
      p1_ff   <= 34'(thi_ff) * 34'(fr_ff);
      far2_ff <= far1_ff;
      e_ff    <= far2_ff ? '0 :
                 lscl_pkg::EXP_W'((35'(p0_ff) + 35'(p1_ff) + 35'd32768) >> 16);
      de_ff   <= 29'(meta_ff[ST+2].diff) * 29'(e_ff);
      n_ff    <= 37'(de_ff) * (meta_ff[ST+3].ext ? 37'd195 : 37'd39);
   end

   // rounding
   logic [20:0] q1_ff [3];
   logic [20:0] q10_ff [2];
   logic [20:0] q100_ff [2];
   logic        big_ff [3];
   logic        mid_ff [3];
   logic [20:0] est10_ff;
   logic [20:0] est100_ff;
   logic [20:0] fin10_ff;
   logic [20:0] fin100_ff;
   logic [20:0] r10;
   logic [20:0] r100;
   logic [lscl_pkg::LUX_W-1:0] mag;
   logic [lscl_pkg::LUX_W-1:0] lux;
   logic [47:0] res_ff;

   assign r10  = q10_ff[1] - 21'(est10_ff * 21'd10);
   assign r100 = q100_ff[1] - 21'(est100_ff * 21'd100);

   always_ff @(posedge clock) begin
      q1_ff[0]   <= 21'((n_ff + 37'd32768) >> 16);
      q10_ff[0]  <= 21'((n_ff + 37'd327680) >> 16);
      q100_ff[0] <= 21'((n_ff + 37'd3276800) >> 16);
      big_ff[0]  <= n_ff > 37'd655360000;
      mid_ff[0]  <= n_ff > 37'd65536000;
      est10_ff   <= 21'((42'(q10_ff[0]) * 42'(R10)) >> 24);
      est100_ff  <= 21'((42'(q100_ff[0]) * 42'(R100)) >> 24);
      q10_ff[1]  <= q10_ff[0];
      q100_ff[1] <= q100_ff[0];
      fin10_ff   <= (r10 >= 21'd10) ? est10_ff + 21'd1 : est10_ff;
      fin100_ff  <= (r100 >= 21'd100) ? est100_ff + 21'd1 : est100_ff;
      for (int i = 1; i < 3; i++) begin
         q1_ff[i]  <= q1_ff[i-1];
         big_ff[i] <= big_ff[i-1];
         mid_ff[i] <= mid_ff[i-1];
      end
   end

   always_comb begin
      if (meta_ff[L-2].neg) begin
         mag = q1_ff[2];
      end else if (big_ff[2]) begin
         mag = 21'(fin100_ff * 21'd100);
      end else if (mid_ff[2]) begin
         mag = 21'(fin10_ff * 21'd10);
      end else begin
         mag = q1_ff[2];
      end
      if (!meta_ff[L-2].live) begin
         lux = '0;
      end else if (meta_ff[L-2].neg) begin
         lux = -mag;
      end else begin
         lux = mag;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= {lux, meta_ff[L-2].count_ch1, meta_ff[L-2].count_ch0, meta_ff[L-2].status};
   end

   // result queue
   logic [47:0]   mem [CAP];
   logic [47:0]   out_ff;
   logic          ov_ff;
   logic          ov_in;
   logic [PW-1:0] wr_ff;
   logic [PW-1:0] wr_in;
   logic [PW-1:0] rd_ff;
   logic [PW-1:0] rd_in;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic [CW-1:0] total_ff;
   logic [CW-1:0] total_in;
   logic          pipe_v;
   logic          take;
   logic          slot;
   logic          load_mem;
   logic          load_pipe;
   logic          push;

   assign pipe_v    = v_ff[L-1];
   assign take      = ov_ff & rsp_tready;
   assign slot      = ~ov_ff | rsp_tready;
   assign load_mem  = (cnt_ff != '0) & slot;
   assign load_pipe = (cnt_ff == '0) & slot & pipe_v;
   assign push      = pipe_v & ~load_pipe;

   always_comb begin
      ov_in    = (load_mem | load_pipe) ? 1'b1 : (take ? 1'b0 : ov_ff);
      cnt_in   = cnt_ff + CW'(push) - CW'(load_mem);
      wr_in    = push ? ((wr_ff == PW'(CAP - 1)) ? '0 : wr_ff + PW'(1)) : wr_ff;
      rd_in    = load_mem ? ((rd_ff == PW'(CAP - 1)) ? '0 : rd_ff + PW'(1)) : rd_ff;
      total_in = total_ff + CW'(acc) - CW'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff    <= 1'b0;
         wr_ff    <= '0;
         rd_ff    <= '0;
         cnt_ff   <= '0;
         total_ff <= '0;
      end else begin
         ov_ff    <= ov_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         cnt_ff   <= cnt_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= res_ff;
      end
      if (load_mem) begin
         out_ff <= mem[rd_ff];
      end else if (load_pipe) begin
         out_ff <= res_ff;
      end
   end

   assign req_tready = total_ff < CW'(CAP);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;

endmodule

// File: rtl/lscl_checker.sv
module lscl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   a_err_lux: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != lscl_pkg::ST_OK |-> rsp_tdata[47:27] == 21'd0)
      else $error("lux nonzero on error status");

   a_undecoded: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == lscl_pkg::ST_CH0_INVALID
                     || rsp_tdata[2:0] == lscl_pkg::ST_CH0_OVERFLOW
                     || rsp_tdata[2:0] == lscl_pkg::ST_CH1_INVALID)
      |-> rsp_tdata[26:15] == 12'd0)
      else $error("count_ch1 set though not decoded");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= lscl_pkg::ST_CH1_OVERFLOW)
      else $error("status out of range");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind light_sensor_code_to_lux_core lscl_checker u_lscl_checker (.*);
